// ----- rtl/core/i5gsdp_pkg.sv -----
// Package with shared types, constants and format helpers for the int5 group dot product.
`timescale 1ns / 1ps
package i5gsdp_pkg;

  localparam int unsigned Columns  = 8;
  localparam int unsigned CodeBits = 5;
  localparam int unsigned ColBits  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_WEIGHT,
    PH_PROD,
    PH_ACC
  } phase_t;

  typedef enum logic {
    FP_MUL,
    FP_ADD
  } fp_op_t;

  typedef struct packed {
    logic   start;
    fp_op_t op;
  } fpu_req_t;

  // Converts an IEEE half-precision pattern to FP32, exactly.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] mt;
    logic [3:0] k;
    logic [7:0] e32;
    logic [9:0] nm;
    sgn = h[15];
    ex  = h[14:10];
    mt  = h[9:0];
    k   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mt[i]) begin
        k = 4'(i);
      end
    end
    e32 = 8'(8'd103 + 8'(k));
    nm  = 10'(mt << (4'd10 - k));
    if (ex == 5'd0) begin
      if (mt == 10'd0) begin
        half_to_f32 = {sgn, 31'd0};
      end else begin
        half_to_f32 = {sgn, e32, nm, 13'd0};
      end
    end else if (ex == 5'h1F) begin
      half_to_f32 = {sgn, 8'hFF, mt, 13'd0};
    end else begin
      half_to_f32 = {sgn, 8'(8'(ex) + 8'd112), mt, 13'd0};
    end
  endfunction

  // Converts a 5-bit weight code (code minus 16) to FP32, exactly.
  function automatic logic [31:0] code_to_f32(input logic [4:0] c);
    logic       sgn;
    logic [4:0] mag;
    logic [2:0] k;
    logic [22:0] fr;
    sgn = ~c[4];
    mag = c[4] ? {1'b0, c[3:0]} : 5'(5'd16 - {1'b0, c[3:0]});
    k   = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (mag[i]) begin
        k = 3'(i);
      end
    end
    fr = 23'({18'd0, mag} << (5'd23 - 5'(k)));
    if (mag == 5'd0) begin
      code_to_f32 = 32'd0;
    end else begin
      code_to_f32 = {sgn, 8'(8'd127 + 8'(k)), fr};
    end
  endfunction

endpackage

// ----- rtl/core/i5gsdp_fpu.sv -----
// Shared two-stage FP32 multiply or add unit with round-to-nearest-even.
`timescale 1ns / 1ps
module i5gsdp_fpu (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i5gsdp_pkg::fpu_req_t req,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output logic                 done,
  output logic [31:0]          result
);
  import i5gsdp_pkg::*;

  logic               v1_r, v2_r;
  logic               sgn_r, sgn_nxt;
  logic signed [10:0] exp_r, exp_nxt;
  logic [47:0]        man_r, man_nxt;
  logic               spec_r, spec_nxt;
  logic [31:0]        specv_r, specv_nxt;
  logic [31:0]        result_r, result_nxt;

  // Stage one: unpack, exact product or aligned sum, special operands.
  always_comb begin
    logic              sa, sb, sx;
    logic [7:0]        ea, eb;
    logic [22:0]       fa, fb;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]       ma, mb, mx, my;
    logic signed [10:0] xa, xb, ex, ey;
    logic              a_big;
    logic [9:0]        dexp;
    logic [26:0]       my3, al;
    logic              stk;
    logic [27:0]       asum;
    sa = a[31]; ea = a[30:23]; fa = a[22:0];
    sb = b[31]; eb = b[30:23]; fb = b[22:0];
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    xa = (ea == 8'd0) ? 11'sd1 : signed'({3'd0, ea});
    xb = (eb == 8'd0) ? 11'sd1 : signed'({3'd0, eb});
    a_big = {ea, fa} >= {eb, fb};
    mx = a_big ? ma : mb;
    my = a_big ? mb : ma;
    ex = a_big ? xa : xb;
    ey = a_big ? xb : xa;
    sx = a_big ? sa : sb;
    dexp = 10'(ex - ey);
    my3  = {my, 3'd0};
    if (dexp >= 10'd27) begin
      al  = 27'd0;
      stk = |my;
    end else begin
      al  = my3 >> dexp[4:0];
      stk = |(my3 & ((27'd1 << dexp[4:0]) - 27'd1));
    end
    if (sa != sb) begin
      asum = {1'b0, mx, 3'd0} - {1'b0, al | {26'd0, stk}};
    end else begin
      asum = {1'b0, mx, 3'd0} + {1'b0, al | {26'd0, stk}};
    end

    if (req.op == FP_MUL) begin
      man_nxt = {24'd0, ma} * {24'd0, mb};
      exp_nxt = xa + xb - 11'sd300;
      sgn_nxt = sa ^ sb;
    end else begin
      man_nxt = {20'd0, asum};
      exp_nxt = ex - 11'sd153;
      // An exact zero sum is negative only when both addends are.
      sgn_nxt = (asum == 28'd0) ? (sa & sb) : sx;
    end

    spec_nxt  = 1'b1;
    specv_nxt = 32'hFFC00000;
    if (a_nan) begin
      specv_nxt = a | 32'h00400000;
    end else if (b_nan) begin
      specv_nxt = b | 32'h00400000;
    end else if (req.op == FP_MUL) begin
      if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        specv_nxt = 32'hFFC00000;
      end else if (a_inf || b_inf) begin
        specv_nxt = {sa ^ sb, 8'hFF, 23'd0};
      end else begin
        spec_nxt = 1'b0;
      end
    end else begin
      if (a_inf && b_inf && (sa != sb)) begin
        specv_nxt = 32'hFFC00000;
      end else if (a_inf) begin
        specv_nxt = a;
      end else if (b_inf) begin
        specv_nxt = b;
      end else begin
        spec_nxt = 1'b0;
      end
    end
  end

  // Stage two: normalize, round to nearest even, pack.
  always_comb begin
    logic [5:0]         p;
    logic signed [10:0] sh_a, sh_b, sh, expf;
    logic [5:0]         shc;
    logic [49:0]        ext, t;
    logic [24:0]        q, qr;
    logic               rnd, stk;
    logic [35:0]        val;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (man_r[i]) begin
        p = 6'(i);
      end
    end
    sh_a = signed'({5'd0, p}) - 11'sd23;
    sh_b = -11'sd149 - exp_r;
    sh   = (sh_a > sh_b) ? sh_a : sh_b;
    ext  = {1'b0, man_r, 1'b0};
    shc  = (sh > 11'sd49) ? 6'd49 : sh[5:0];
    t    = ext >> shc;
    if (sh > 11'sd0) begin
      q   = t[25:1];
      rnd = t[0];
      stk = |(ext & ((50'd1 << shc) - 50'd1));
    end else begin
      q   = 25'(man_r << 5'(-sh));
      rnd = 1'b0;
      stk = 1'b0;
    end
    qr   = q + {24'd0, rnd & (stk | q[0])};
    expf = sh + exp_r + 11'sd149;
    val  = {{2{expf[10]}}, expf, 23'd0} + {11'd0, qr};
    if (spec_r) begin
      result_nxt = specv_r;
    end else if (man_r == 48'd0) begin
      result_nxt = {sgn_r, 31'd0};
    end else if (!val[35] && (val >= 36'h07F800000)) begin
      result_nxt = {sgn_r, 8'hFF, 23'd0};
    end else begin
      result_nxt = {sgn_r, val[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
    end
    if (req.start) begin
      sgn_r   <= sgn_nxt;
      exp_r   <= exp_nxt;
      man_r   <= man_nxt;
      spec_r  <= spec_nxt;
      specv_r <= specv_nxt;
    end
    if (v1_r) begin
      result_r <= result_nxt;
    end
  end

  assign done   = v2_r;
  assign result = result_r;

endmodule

// ----- rtl/core/int5_group_scaled_dot_product.sv -----
// Top level of the int5 group-quantized scaled dot product block.
`timescale 1ns / 1ps
// Usage: each input word is one block of eight columns: eight packed 5-bit
// weight codes, the half-precision scale of its group, eight FP32
// activations and a last flag. Words are accepted when in_valid is high and
// in_stall is low; the block raises in_stall while it works on a word.
// Each column takes three FP32 operations in order: weight times scale,
// that product times the activation, and the add into the running sum.
// All of them go through one shared two-stage multiply/add unit: each
// operation is issued in ST_ISSUE and waits in ST_WAIT through both unit
// stages. No new word is taken before the last add of a word is done.
// On a word marked last, ST_FLUSH then moves the sum to the output register
// and returns the running sum to positive zero; otherwise no result
// word is produced. The result word waits in the output register while
// out_stall is high; a following last word is held until it is taken.
// Reset clears the running sum to positive zero and drops out_valid.
module int5_group_scaled_dot_product (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [39:0] in_packed_codes,
  input  logic [15:0] in_group_scale,
  input  logic [31:0] in_activation_0,
  input  logic [31:0] in_activation_1,
  input  logic [31:0] in_activation_2,
  input  logic [31:0] in_activation_3,
  input  logic [31:0] in_activation_4,
  input  logic [31:0] in_activation_5,
  input  logic [31:0] in_activation_6,
  input  logic [31:0] in_activation_7,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_dot_sum
);
  import i5gsdp_pkg::*;

  state_t              state_r, state_nxt;
  phase_t              ph_r;
  logic [ColBits-1:0]  col_r;
  logic [39:0]         codes_r;
  logic [31:0]         scale_r;
  logic [31:0]         acts_r [Columns];
  logic                last_r;
  logic [31:0]         sum_r;
  logic [31:0]         tmp_r;
  logic                out_valid_r;
  logic [31:0]         out_dot_sum_r;

  fpu_req_t            req;
  logic [31:0]         opa, opb;
  logic                fpu_done;
  logic [31:0]         fpu_res;
  logic                accept;
  logic                final_op;
  logic                flush_go;
  logic [5:0]          code_pos;

  assign accept   = in_valid && !in_stall;
  assign final_op = (ph_r == PH_ACC) && (col_r == ColBits'(Columns - 1));
  assign flush_go = (state_r == ST_FLUSH) && (!out_valid_r || !out_stall);
  assign code_pos = 6'({col_r, 2'b00}) + 6'(col_r);

  // Next-state logic of the column sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (fpu_done) begin
          if (final_op) begin
            state_nxt = last_r ? ST_FLUSH : ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: handshake and operand selection.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    req.start = (state_r == ST_ISSUE);
    req.op    = FP_MUL;
    opa       = tmp_r;
    opb       = acts_r[col_r];
    case (ph_r)
      PH_WEIGHT: begin
        opa = code_to_f32(codes_r[code_pos +: CodeBits]);
        opb = scale_r;
      end
      PH_PROD: begin
        opa = tmp_r;
        opb = acts_r[col_r];
      end
      PH_ACC: begin
        req.op = FP_ADD;
        opa    = sum_r;
        opb    = tmp_r;
      end
      default: begin
        req.op = FP_MUL;
      end
    endcase
  end

  i5gsdp_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .a      (opa),
    .b      (opb),
    .done   (fpu_done),
    .result (fpu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_WEIGHT;
      col_r       <= '0;
      sum_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        ph_r  <= PH_WEIGHT;
        col_r <= '0;
      end else if ((state_r == ST_WAIT) && fpu_done) begin
        case (ph_r)
          PH_WEIGHT: ph_r <= PH_PROD;
          PH_PROD:   ph_r <= PH_ACC;
          PH_ACC: begin
            ph_r  <= PH_WEIGHT;
            col_r <= col_r + ColBits'(1);
          end
          default:   ph_r <= PH_WEIGHT;
        endcase
        if (ph_r == PH_ACC) begin
          sum_r <= fpu_res;
        end
      end
      if (flush_go) begin
        out_valid_r <= 1'b1;
        sum_r       <= 32'd0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      codes_r   <= in_packed_codes;
      scale_r   <= half_to_f32(in_group_scale);
      acts_r[0] <= in_activation_0;
      acts_r[1] <= in_activation_1;
      acts_r[2] <= in_activation_2;
      acts_r[3] <= in_activation_3;
      acts_r[4] <= in_activation_4;
      acts_r[5] <= in_activation_5;
      acts_r[6] <= in_activation_6;
      acts_r[7] <= in_activation_7;
      last_r    <= in_last_block;
    end
    if ((state_r == ST_WAIT) && fpu_done && (ph_r != PH_ACC)) begin
      tmp_r <= fpu_res;
    end
    if (flush_go) begin
      out_dot_sum_r <= sum_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dot_sum = out_dot_sum_r;

endmodule
